[design/fwrm_pkg.sv]
// shared types and constants of the firewall rule matcher
package fwrm_pkg;

    // default size of the rule table
    localparam int RULE_DEPTH_DEF = 64;

    // field widths
    localparam int CLASS_W = 2;
    localparam int PORT_W  = 16;
    localparam int ADDR_W  = 32;

    // request kinds carried on s_tuser
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 8;

    // one stored rule
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [PORT_W-1:0]  port_last;
        logic [PORT_W-1:0]  port_first;
        logic [ADDR_W-1:0]  addr_last;
        logic [ADDR_W-1:0]  addr_first;
    } rule_t;

    // packet fields of a check request
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [PORT_W-1:0]  port;
        logic [ADDR_W-1:0]  addr;
    } key_t;

endpackage

[design/fwrm_rule_mem.sv]
// rule table memory with one write port and one registered read port
module fwrm_rule_mem #(
    parameter int RULE_DEPTH = fwrm_pkg::RULE_DEPTH_DEF,
    parameter int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  fwrm_pkg::rule_t      wr_rule,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output fwrm_pkg::rule_t      rd_rule
);

    fwrm_pkg::rule_t mem [RULE_DEPTH];
    fwrm_pkg::rule_t rd_rule_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_rule;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_rule_reg <= mem[rd_addr];
        end
    end

    assign rd_rule = rd_rule_reg;

endmodule

[design/fwrm_match_unit.sv]
// shared compare unit: tests one rule against the packet key
module fwrm_match_unit (
    input  fwrm_pkg::rule_t rule,
    input  fwrm_pkg::key_t  key,
    output logic            hit
);

    logic cls_eq;
    logic port_in;
    logic addr_in;

    // class equality and inclusive range checks
    assign cls_eq  = (rule.cls == key.cls);
    assign port_in = (key.port >= rule.port_first) && (key.port <= rule.port_last);
    assign addr_in = (key.addr >= rule.addr_first) && (key.addr <= rule.addr_last);

    assign hit = cls_eq && port_in && addr_in;

endmodule

[design/firewall_rule_match.sv]
// top level of the firewall rule matcher: sequencer, output register, table
//
// Usage: requests enter on the s_ stream, one result per request leaves on the
// m_ stream. s_tuser selects the request kind: 0 adds a rule to the next free
// table entry, 1 checks a packet against the stored rules.
// An add passes through the result state on its way to m_tvalid. A full table
// drops the rule and answers status 1.
// A check scans the stored rules one per cycle through the shared compare
// unit, fed by the table's single registered read port; it stops at the
// first matching rule.
// One request is processed at a time; s_tready is low from acceptance until
// the result has been moved into the output register.
// The output register holds the result while m_tready is low; the block then
// waits with its finished result and takes no new request until the output
// register frees up. Once the result is registered, the next request may be
// accepted while that result is still waiting.
// Reset empties the table (rule count back to zero) and drops any pending
// result; the table contents themselves are not cleared.
module firewall_rule_match #(
    parameter int RULE_DEPTH = fwrm_pkg::RULE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // traffic_class, port_first, port_last, addr_first, addr_last, 6 zero bits
    input  logic [fwrm_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accepted, status, 6 zero bits
    output logic [fwrm_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RULE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  scan_reg, scan_next;
    logic                              pend_reg, pend_next;
    fwrm_pkg::key_t                    key_reg, key_next;
    logic                              acc_reg, acc_next;
    logic                              stat_reg, stat_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [1:0]                        m_res_reg, m_res_next;

    fwrm_pkg::rule_t                   in_rule;
    fwrm_pkg::rule_t                   rd_rule;
    logic                              wr_en;
    logic                              rd_en;
    logic                              issue;
    logic                              hit;
    logic                              full;

    // unpack the request payload
    assign in_rule.cls        = s_tdata[1:0];
    assign in_rule.port_first = s_tdata[17:2];
    assign in_rule.port_last  = s_tdata[33:18];
    assign in_rule.addr_first = s_tdata[65:34];
    assign in_rule.addr_last  = s_tdata[97:66];

    assign full  = (count_reg == CNT_W'(RULE_DEPTH));
    assign issue = (scan_reg < count_reg);

    // rule table
    fwrm_rule_mem #(
        .RULE_DEPTH (RULE_DEPTH),
        .IDX_W      (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_rule (in_rule),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_rule (rd_rule)
    );

    // compare unit shared by every scan step
    fwrm_match_unit u_match (
        .rule (rd_rule),
        .key  (key_reg),
        .hit  (hit)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        key_next      = key_reg;
        acc_next      = acc_reg;
        stat_next     = stat_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_res_next    = m_res_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next.cls  = in_rule.cls;
                    key_next.port = in_rule.port_first;
                    key_next.addr = in_rule.addr_first;
                    scan_next     = '0;
                    acc_next      = 1'b0;
                    stat_next     = fwrm_pkg::STATUS_OK;
                    if (s_tuser == fwrm_pkg::FUNC_ADD) begin
                        if (full) begin
                            stat_next = fwrm_pkg::STATUS_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read the next rule while the previous one is compared
                rd_en     = issue;
                pend_next = issue;
                if (issue) begin
                    scan_next = scan_reg + 1'b1;
                end
                if (pend_reg && hit) begin
                    acc_next   = 1'b1;
                    state_next = ST_RESULT;
                end else if (!issue) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = {stat_reg, acc_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        acc_reg   <= acc_next;
        stat_reg  <= stat_next;
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(fwrm_pkg::M_TDATA_W - 2)'(0), m_res_reg};

endmodule

[design/fwrm_checker.sv]
// port-level checker for the firewall rule matcher, bound to the top level
module fwrm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fwrm_pkg::M_TDATA_W-1:0]  m_tdata
);

    // one request at a time: busy right after an accepted request
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("request accepted while previous one in flight");

    // a stalled result holds
    a_result_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))
    ) else $error("stalled result changed");

    // a result never reports both a match and a dropped add
    a_acc_stat_excl: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1])
    ) else $error("result shows match and table full together");

    // an accepted request yields no result in the very next cycle
    a_no_instant_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid
    ) else $error("result appeared one cycle after request");

endmodule

bind firewall_rule_match fwrm_checker u_fwrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/tb_firewall_rule_match.sv]
// self-checking testbench for the firewall rule matcher
`timescale 1ns / 1ps

module tb_firewall_rule_match;

    localparam int RULE_DEPTH     = fwrm_pkg::RULE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 750;
    localparam int QUIET_ITEMS    = 100;
    localparam int WATCHDOG_LIMIT = 2000;

    // one request as the block sees it
    typedef struct packed {
        logic                         func;
        logic [fwrm_pkg::CLASS_W-1:0] cls;
        logic [fwrm_pkg::PORT_W-1:0]  port_first;
        logic [fwrm_pkg::PORT_W-1:0]  port_last;
        logic [fwrm_pkg::ADDR_W-1:0]  addr_first;
        logic [fwrm_pkg::ADDR_W-1:0]  addr_last;
    } req_t;

    // one result
    typedef struct packed {
        logic accepted;
        logic status;
    } verdict_t;

    // directed row: request plus an optional hand-written result
    typedef struct packed {
        req_t     req;
        logic     typed;
        verdict_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [20] = '{
        // empty table never accepts
        '{'{fwrm_pkg::FUNC_CHECK, 2'd0, 16'd0, 16'd0, 32'd0, 32'd0},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        // catch-all rule for class 0
        '{'{fwrm_pkg::FUNC_ADD, 2'd0, 16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd0, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'd0},
          1'b1, '{1'b1, fwrm_pkg::STATUS_OK}},
        // no rule of this class yet
        '{'{fwrm_pkg::FUNC_CHECK, 2'd1, 16'd0, 16'd0, 32'd0, 32'd0},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        // single port, single address
        '{'{fwrm_pkg::FUNC_ADD, 2'd1, 16'd80, 16'd80, 32'h0A00_0001, 32'h0A00_0001},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd1, 16'd80, 16'hFFFF, 32'h0A00_0001, 32'hFFFF_FFFF},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd1, 16'd81, 16'd0, 32'h0A00_0001, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd1, 16'd80, 16'd0, 32'h0A00_0002, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        // reversed port range holds nothing
        '{'{fwrm_pkg::FUNC_ADD, 2'd2, 16'd100, 16'd50, 32'd0, 32'hFFFF_FFFF},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd75, 16'd0, 32'd5, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        // reversed address range holds nothing
        '{'{fwrm_pkg::FUNC_ADD, 2'd3, 16'd0, 16'hFFFF, 32'h20, 32'h10},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd3, 16'd1, 16'd0, 32'h18, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        // two neighbor rules: port of one and address of the other must not combine
        '{'{fwrm_pkg::FUNC_ADD, 2'd2, 16'd1000, 16'd2000, 32'hC0A8_0000, 32'hC0A8_00FF},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_ADD, 2'd2, 16'd1500, 16'd3000, 32'hC0A8_0100, 32'hC0A8_01FF},
          1'b1, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd1000, 16'd0, 32'hC0A8_0000, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd2000, 16'd0, 32'hC0A8_00FF, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd2001, 16'd0, 32'hC0A8_00FF, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd999, 16'd0, 32'hC0A8_0000, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd2, 16'd1200, 16'd0, 32'hC0A8_0180, 32'd0},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}},
        '{'{fwrm_pkg::FUNC_CHECK, 2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
          1'b0, '{1'b0, fwrm_pkg::STATUS_OK}}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [fwrm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fwrm_pkg::M_TDATA_W-1:0] m_tdata;

    // predictor state: copy of the rule table
    fwrm_pkg::rule_t acl_table [RULE_DEPTH];
    int unsigned     acl_count = 0;

    verdict_t pending_verdicts [$];
    int       mismatch_count = 0;
    bit       idling_on      = 1'b1;
    bit       cur_typed      = 1'b0;
    verdict_t cur_want       = '0;
    int       stall_left     = 0;
    int       quiet_cycles   = 0;

    firewall_rule_match #(
        .RULE_DEPTH(RULE_DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // add appends to the table, check scans for a rule of the same class holding both port and address
    function automatic verdict_t apply_request(input req_t r);
        verdict_t        v;
        fwrm_pkg::rule_t e;
        v = '{accepted: 1'b0, status: fwrm_pkg::STATUS_OK};
        if (r.func == fwrm_pkg::FUNC_ADD) begin
            if (acl_count < RULE_DEPTH) begin
                e.cls        = r.cls;
                e.port_first = r.port_first;
                e.port_last  = r.port_last;
                e.addr_first = r.addr_first;
                e.addr_last  = r.addr_last;
                acl_table[acl_count] = e;
                acl_count++;
            end else begin
                v.status = fwrm_pkg::STATUS_FULL;
            end
        end else begin
            for (int i = 0; i < acl_count; i++) begin
                e = acl_table[i];
                if (e.cls == r.cls &&
                    r.port_first >= e.port_first && r.port_first <= e.port_last &&
                    r.addr_first >= e.addr_first && r.addr_first <= e.addr_last) begin
                    v.accepted = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // random range: single value, full, reversed or of random width
    function automatic logic [63:0] random_span(input logic [31:0] mask);
        logic [31:0]     lo;
        logic [31:0]     hi;
        longint unsigned top;
        lo = $urandom & mask;
        hi = $urandom & mask;
        case ($urandom_range(9, 0))
            0: hi = lo;
            1: begin
                lo = '0;
                hi = mask;
            end
            2: if (lo < hi) begin
                {lo, hi} = {hi, lo};
            end
            default: begin
                top = 64'(lo) + 64'((($urandom & mask) >> $urandom_range(31, 0)));
                hi = (top > 64'(mask)) ? mask : 32'(top);
            end
        endcase
        return {lo, hi};
    endfunction

    // value inside a range, on its edges, just outside, or anywhere
    function automatic logic [31:0] near_range(input logic [31:0] lo, input logic [31:0] hi,
                                                input logic [31:0] mask);
        longint unsigned span;
        logic [31:0]     v;
        v = $urandom;
        case ($urandom_range(5, 0))
            0, 1: if (lo <= hi) begin
                span = 64'(hi) - 64'(lo) + 1;
                v = lo + 32'({$urandom} % span);
            end
            2: v = lo;
            3: v = hi;
            4: v = $urandom_range(1, 0) ? lo - 1 : hi + 1;
            default: ;
        endcase
        return v & mask;
    endfunction

    function automatic req_t random_request();
        req_t            r;
        fwrm_pkg::rule_t e;
        logic [63:0]     span;
        r.cls        = fwrm_pkg::CLASS_W'($urandom);
        r.port_last  = fwrm_pkg::PORT_W'($urandom);
        r.addr_last  = $urandom;
        r.port_first = fwrm_pkg::PORT_W'($urandom);
        r.addr_first = $urandom;
        if ($urandom_range(3, 0) == 0) begin
            r.func = fwrm_pkg::FUNC_ADD;
            span = random_span(32'hFFFF);
            r.port_first = span[47:32];
            r.port_last  = span[15:0];
            span = random_span(32'hFFFF_FFFF);
            r.addr_first = span[63:32];
            r.addr_last  = span[31:0];
        end else begin
            r.func = fwrm_pkg::FUNC_CHECK;
            // most checks aim at a stored rule
            if (acl_count > 0 && $urandom_range(3, 0) != 0) begin
                e = acl_table[$urandom_range(acl_count - 1, 0)];
                if ($urandom_range(7, 0) != 0) begin
                    r.cls = e.cls;
                end
                r.port_first = 16'(near_range(32'(e.port_first), 32'(e.port_last), 32'hFFFF));
                r.addr_first = near_range(e.addr_first, e.addr_last, 32'hFFFF_FFFF);
            end
        end
        return r;
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_request(input req_t r, input bit typed, input verdict_t want);
        if (idling_on && $urandom_range(3, 0) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge aclk);
        end
        cur_typed = typed;
        cur_want  = want;
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {6'd0, r.addr_last, r.addr_first, r.port_last, r.port_first, r.cls};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(4, 0) == 0) begin
            stall_left = $urandom_range(6, 1) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // predict on each accepted request, compare each result with the oldest prediction
    always @(posedge aclk) begin
        req_t     r;
        verdict_t v;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                r.func       = s_tuser;
                r.cls        = s_tdata[1:0];
                r.port_first = s_tdata[17:2];
                r.port_last  = s_tdata[33:18];
                r.addr_first = s_tdata[65:34];
                r.addr_last  = s_tdata[97:66];
                v = apply_request(r);
                pending_verdicts = {pending_verdicts, (cur_typed ? cur_want : v)};
            end
            if (m_tvalid && m_tready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no request pending", int'(m_tdata), -1);
                end else begin
                    v = pending_verdicts.pop_front();
                    if (m_tdata[0] !== v.accepted) begin
                        report_mismatch("accepted", int'(m_tdata[0]), int'(v.accepted));
                    end
                    if (m_tdata[1] !== v.status) begin
                        report_mismatch("status", int'(m_tdata[1]), int'(v.status));
                    end
                    if (m_tdata[fwrm_pkg::M_TDATA_W-1:2] !== '0) begin
                        report_mismatch("padding", int'(m_tdata[fwrm_pkg::M_TDATA_W-1:2]), 0);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests
        foreach (DIRECTED_ROWS[i]) begin
            send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // random requests, idling in bursts with some quiet stretches, none at the end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idling_on = (n < RANDOM_ITEMS - QUIET_ITEMS) && ((n / 80) % 3 != 2);
            send_request(random_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (RULE_DEPTH + 8) @(posedge aclk);

        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
design/fwrm_pkg.sv
design/fwrm_rule_mem.sv
design/fwrm_match_unit.sv
design/firewall_rule_match.sv
design/fwrm_checker.sv
sim/tb_firewall_rule_match.sv
